### hw/rtl/tpd_pkg.sv
`default_nettype none

package tpd_pkg;

    localparam int ROW_W            = 32;
    localparam int TILE_ROWS        = 8;
    localparam int ROW_NUM_W        = 3;
    localparam int INDEX_W          = 8;
    localparam int MAX_PATTERNS_DEF = 256;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [ROW_NUM_W-1:0] LAST_ROW = ROW_NUM_W'(TILE_ROWS - 1);

    // One whole tile, row 0 in the lowest slot
    typedef logic [TILE_ROWS-1:0][ROW_W-1:0] tile_t;

    // Queue status seen by the top level (for busy) and by the back
    typedef struct packed {
        logic full;
        logic not_empty;
    } q_status_t;

endpackage

`default_nettype wire

### hw/rtl/tpd_front.sv
`default_nettype none

module tpd_front
    import tpd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 accept,
    input  wire logic [ROW_W-1:0]     row_pixels,
    input  wire logic [ROW_NUM_W-1:0] row_number,
    output logic                      push,
    output tile_t                     tile
);

    tile_t buf_reg;

    // Rows land in the slot named by their row number; slots are never cleared
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            buf_reg[row_number] <= row_pixels;
        end
    end

    // The last row completes the tile: merge it in on the way to the queue
    always_comb
    begin
        tile           = buf_reg;
        tile[LAST_ROW] = row_pixels;
        push           = accept && (row_number == LAST_ROW);
    end

endmodule

`default_nettype wire

### hw/rtl/tpd_queue.sv
`default_nettype none

module tpd_queue
    import tpd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire tile_t push_tile,
    input  wire logic  pop,
    output tile_t      pop_tile,
    output q_status_t  status
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    tile_t              slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic               do_push, do_pop;

    assign status.full      = (fill_reg == CNT_W'(QUEUE_DEPTH));
    assign status.not_empty = (fill_reg != '0);
    assign do_push          = push && !status.full;
    assign do_pop           = pop && status.not_empty;
    assign pop_tile         = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_tile;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/tpd_back.sv
`default_nettype none

module tpd_back
    import tpd_pkg::*;
#(
    parameter int MAX_PATTERNS = MAX_PATTERNS_DEF
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire q_status_t     q_status,
    input  wire tile_t         q_tile,
    output logic               pop,
    output logic               done,
    output logic [INDEX_W-1:0] tile_index,
    output logic               was_new,
    output logic               store_full
);

    localparam int IDX_W = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
    localparam int CNT_W = $clog2(MAX_PATTERNS + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    // Pattern store: one whole tile per entry, one read or one write a cycle
    tile_t              pat_mem [MAX_PATTERNS];
    tile_t              rd_data_reg;
    tile_t              tile_reg, tile_next;

    logic               state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   scan_idx_reg, scan_idx_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic               done_reg, done_next;
    logic [INDEX_W-1:0] index_reg, index_next;
    logic               new_reg, new_next;
    logic               full_reg, full_next;

    logic               mem_re, mem_we;
    logic               hit;

    assign hit = cmp_valid_reg && (rd_data_reg == tile_reg);

    always_comb
    begin
        state_next     = state_reg;
        tile_next      = tile_reg;
        count_next     = count_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        done_next      = 1'b0;
        index_next     = index_reg;
        new_next       = new_reg;
        full_next      = full_reg;
        mem_re         = 1'b0;
        mem_we         = 1'b0;
        pop            = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_status.not_empty)
                begin
                    pop           = 1'b1;
                    tile_next     = q_tile;
                    scan_idx_next = '0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    // First match in insertion order wins
                    done_next  = 1'b1;
                    index_next = INDEX_W'(cmp_idx_reg);
                    new_next   = 1'b0;
                    full_next  = 1'b0;
                    state_next = ST_IDLE;
                end
                else if (scan_idx_reg < count_reg)
                begin
                    // Issue the next read; compare it in the following cycle
                    mem_re         = 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_idx_reg[IDX_W-1:0];
                    scan_idx_next  = scan_idx_reg + 1'b1;
                end
                else
                begin
                    done_next  = 1'b1;
                    new_next   = 1'b0;
                    state_next = ST_IDLE;
                    if (count_reg == CNT_W'(MAX_PATTERNS))
                    begin
                        index_next = '0;
                        full_next  = 1'b1;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        index_next = INDEX_W'(count_reg[IDX_W-1:0]);
                        new_next   = 1'b1;
                        full_next  = 1'b0;
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_idx_reg  <= scan_idx_next;
            cmp_valid_reg <= cmp_valid_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tile_reg    <= tile_next;
        cmp_idx_reg <= cmp_idx_next;
        index_reg   <= index_next;
        new_reg     <= new_next;
        full_reg    <= full_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pat_mem[count_reg[IDX_W-1:0]] <= tile_reg;
        end
        if (mem_re)
        begin
            rd_data_reg <= pat_mem[scan_idx_reg[IDX_W-1:0]];
        end
    end

    assign done       = done_reg;
    assign tile_index = index_reg;
    assign was_new    = new_reg;
    assign store_full = full_reg;

endmodule

`default_nettype wire

### hw/rtl/tile_pattern_dedup.sv
`default_nettype none

// Tile deduplicator for 8x8 tiles of 4-bit pixels. Send each tile as eight row
// transfers (start high while busy is low), leftmost pixel in the top nibble of
// row_pixels; row 7 completes the tile. Rows may be skipped or repeated: a slot
// keeps whatever row was last written to it. For every completed tile one result
// appears on tile_index/was_new/store_full for exactly one cycle, marked by done;
// the receiver cannot stall it, so sample it when done is high. tile_index is the
// first stored pattern (in insertion order) equal to the tile, or the index at
// which the tile was just appended (was_new high). If nothing matches and the
// store already holds MAX_PATTERNS patterns, store_full is high, tile_index is 0
// and nothing is stored. The store is empty after reset, with no clearing pass.
// Flow: a row is taken whenever start is high and busy is low. A completed tile
// waits in a two-entry queue; the search engine then reads one stored pattern
// per cycle from its single-port pattern memory, scanning N stored patterns for
// each tile (index of the hit plus one, or the whole count on a miss). busy
// rises only while the queue holds two unsearched tiles.

module tile_pattern_dedup
    import tpd_pkg::*;
#(
    parameter int MAX_PATTERNS = MAX_PATTERNS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [ROW_W-1:0]     row_pixels,
    input  wire logic [ROW_NUM_W-1:0] row_number,
    output logic                      done,
    output logic [INDEX_W-1:0]        tile_index,
    output logic                      was_new,
    output logic                      store_full
);

    logic      accept;
    logic      push;
    logic      pop;
    tile_t     push_tile;
    tile_t     pop_tile;
    q_status_t q_status;

    // Hold off new rows only while the queue cannot take a finished tile
    assign busy   = q_status.full;
    assign accept = start && !busy;

    tpd_front u_front (
        .clk        (clk),
        .accept     (accept),
        .row_pixels (row_pixels),
        .row_number (row_number),
        .push       (push),
        .tile       (push_tile)
    );

    tpd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_tile (push_tile),
        .pop       (pop),
        .pop_tile  (pop_tile),
        .status    (q_status)
    );

    tpd_back #(
        .MAX_PATTERNS (MAX_PATTERNS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .q_tile     (pop_tile),
        .pop        (pop),
        .done       (done),
        .tile_index (tile_index),
        .was_new    (was_new),
        .store_full (store_full)
    );

endmodule

`default_nettype wire
